[design/text_console_writer_macros.svh]
// Assertion macros shared by the console writer modules
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define TCW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/tcw_pkg.sv]
// Types, constants and codes of the text console writer
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_WIDTH  = 8;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int TAB_SHIFT  = $clog2(TAB_WIDTH);

  // Widths
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int COL_W  = $clog2(COLUMNS + TAB_WIDTH);
  localparam int ROW_W  = $clog2(ROWS + 1);
  localparam int LOC_W  = 11;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;
  localparam int CHAR_W = 8;
  localparam int FUNC_W = 2;

  // Operation codes
  localparam logic [FUNC_W-1:0] OP_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] OP_READ  = 2'd2;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] char_code;
    logic [LOC_W-1:0]  cell_index;
  } in_item_t;

  typedef struct packed {
    logic [LOC_W-1:0]  cursor_location;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_SETTLE,
    ST_IDLE,
    ST_EXEC,
    ST_COPY,
    ST_BLANK,
    ST_DONE
  } tcw_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic exec;
    logic copy_step;
    logic blank_step;
    logic init_fill;
  } tcw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              put_wrap;
    logic              ptr_copy_last;
    logic              ptr_last;
  } tcw_sts_t;

endpackage

[design/tcw_ctrl.sv]
// Sequencing state machine of the text console writer
`include "text_console_writer_macros.svh"

module tcw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  tcw_pkg::tcw_sts_t sts,
  output tcw_pkg::tcw_cmd_t cmd,
  output logic              busy,
  output logic              out_valid
);
  import tcw_pkg::*;

  tcw_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_INIT: begin
        cmd.blank_step = 1'b1;
        cmd.init_fill  = 1'b1;
        if (sts.ptr_last) state_nxt = ST_SETTLE;
      end
      ST_SETTLE: begin
        // hold busy while the last blank write lands
        state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        case (sts.func)
          OP_PUT:   state_nxt = sts.put_wrap ? ST_COPY : ST_DONE;
          OP_CLEAR: state_nxt = ST_BLANK;
          default:  state_nxt = ST_DONE;
        endcase
      end
      ST_COPY: begin
        cmd.copy_step = 1'b1;
        if (sts.ptr_copy_last) state_nxt = ST_BLANK;
      end
      ST_BLANK: begin
        cmd.blank_step = 1'b1;
        if (sts.ptr_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `TCW_ASSERT_NEXT(a_accept_exec, clk, rst_n, state_r == ST_IDLE && start, state_r == ST_EXEC, "accepted item did not enter execution")
  `TCW_ASSERT_NEXT(a_done_once, clk, rst_n, state_r == ST_DONE, state_r == ST_IDLE, "result strobe lasted more than one cycle")
  `TCW_ASSERT_NEXT(a_copy_only_put, clk, rst_n, state_r == ST_EXEC && sts.func != OP_PUT, state_r != ST_COPY, "scroll started by an operation other than put")

endmodule

[design/tcw_datapath.sv]
// Cell store, cursor, attribute and result registers of the text console writer
`include "text_console_writer_macros.svh"

module tcw_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  tcw_pkg::in_item_t   in_item,
  input  logic                cfg_valid,
  input  logic [7:0]          cfg_data,
  input  tcw_pkg::tcw_cmd_t   cmd,
  output tcw_pkg::tcw_sts_t   sts,
  output tcw_pkg::out_item_t  out_item
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] rd_data_r;
  logic [ADDR_W-1:0] rd_addr;

  logic              wr_pend_r, wr_pend_nxt;
  logic              wr_copy_r, wr_copy_nxt;
  logic [ADDR_W-1:0] wr_addr_r, wr_addr_nxt;
  logic [CELL_W-1:0] wr_data_r, wr_data_nxt;

  in_item_t          req_r;
  logic [ATTR_W-1:0] attr_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ADDR_W-1:0] ptr_r;
  logic [CELL_W-1:0] data_r;
  logic              scrolled_r;

  logic [COL_W-1:0]  col_put, col_tab;
  logic [ROW_W-1:0]  row_put;
  logic              put_write, put_wrap;
  logic [ADDR_W-1:0] cur_pos;
  logic              idx_ok;
  logic [CELL_W-1:0] blank;

  assign cur_pos = ADDR_W'(row_r * COLUMNS) + ADDR_W'(col_r);
  assign col_tab = COL_W'(((col_r >> TAB_SHIFT) + 1) << TAB_SHIFT);
  assign idx_ok  = req_r.cell_index < LOC_W'(CELL_COUNT);
  assign blank   = cmd.init_fill ? {ATTR_RESET, CH_SPACE} : {attr_r, CH_SPACE};

  // Cursor motion for one put
  always_comb begin
    col_put   = col_r;
    row_put   = row_r;
    put_write = 1'b0;
    case (req_r.char_code)
      CH_BACKSPACE: begin
        if (col_r != '0) col_put = col_r - 1'b1;
      end
      CH_TAB: col_put = col_tab;
      CH_CR:  col_put = '0;
      CH_LF: begin
        col_put = '0;
        row_put = row_r + 1'b1;
      end
      default: begin
        if (req_r.char_code >= CH_SPACE && !req_r.char_code[CHAR_W-1]) begin
          put_write = 1'b1;
          col_put   = col_r + 1'b1;
        end
      end
    endcase
    if (col_put >= COL_W'(COLUMNS)) begin
      col_put = '0;
      row_put = row_put + 1'b1;
    end
    put_wrap = row_put >= ROW_W'(ROWS);
    if (put_wrap) row_put = ROW_W'(ROWS - 1);
  end

  // Read address: copy source while scrolling, else the incoming index, or zero when it is past the store
  always_comb begin
    if (cmd.copy_step) begin
      rd_addr = ptr_r + ADDR_W'(COLUMNS);
    end else if (in_item.cell_index < LOC_W'(CELL_COUNT)) begin
      rd_addr = ADDR_W'(in_item.cell_index);
    end else begin
      rd_addr = '0;
    end
  end

  // Writes are registered and land in the cycle after, so copies can use the registered read
  always_comb begin
    wr_pend_nxt = 1'b0;
    wr_copy_nxt = 1'b0;
    wr_addr_nxt = ptr_r;
    wr_data_nxt = blank;
    col_nxt     = col_r;
    row_nxt     = row_r;
    if (cmd.copy_step) begin
      wr_pend_nxt = 1'b1;
      wr_copy_nxt = 1'b1;
    end else if (cmd.blank_step) begin
      wr_pend_nxt = 1'b1;
    end else if (cmd.exec) begin
      case (req_r.func)
        OP_PUT: begin
          wr_pend_nxt = put_write;
          wr_addr_nxt = cur_pos;
          wr_data_nxt = {attr_r, req_r.char_code};
          col_nxt     = col_put;
          row_nxt     = row_put;
        end
        OP_CLEAR: begin
          col_nxt = '0;
          row_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (wr_pend_r) begin
      mem[wr_addr_r] <= wr_copy_r ? rd_data_r : wr_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pend_r  <= 1'b0;
      attr_r     <= ATTR_RESET;
      col_r      <= '0;
      row_r      <= '0;
      ptr_r      <= '0;
      scrolled_r <= 1'b0;
    end else begin
      wr_pend_r <= wr_pend_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      if (cfg_valid) attr_r <= cfg_data;
      if (cmd.accept) begin
        ptr_r      <= '0;
        scrolled_r <= 1'b0;
      end else if (cmd.copy_step || cmd.blank_step) begin
        ptr_r <= ptr_r + 1'b1;
      end
      if (cmd.exec && req_r.func == OP_PUT) scrolled_r <= put_wrap;
    end
  end

  always_ff @(posedge clk) begin
    wr_copy_r <= wr_copy_nxt;
    wr_addr_r <= wr_addr_nxt;
    wr_data_r <= wr_data_nxt;
    if (cmd.accept) begin
      req_r  <= in_item;
      data_r <= '0;
    end else if (cmd.exec && req_r.func == OP_READ) begin
      data_r <= idx_ok ? rd_data_r : '0;
    end
  end

  assign sts.func          = req_r.func;
  assign sts.put_wrap      = put_wrap;
  assign sts.ptr_copy_last = ptr_r == ADDR_W'(CELL_COUNT - COLUMNS - 1);
  assign sts.ptr_last      = ptr_r == ADDR_W'(CELL_COUNT - 1);

  assign out_item.cursor_location = LOC_W'(cur_pos);
  assign out_item.cell_data       = data_r;
  assign out_item.scrolled        = scrolled_r;

  `TCW_ASSERT_NOW(a_row_in_range, clk, rst_n, 1'b1, row_r < ROW_W'(ROWS), "cursor row beyond last row")

endmodule

[design/text_console_writer.sv]
// Top level of the text console writer: controller plus datapath
//
// Text-mode console engine over an 80x25 store of 16-bit cells
// (attribute in the high byte, character in the low byte).
// Command channel: present in_item and raise start; the item transfers
// at a rising edge with start high and busy low. func selects put
// character, clear screen or read cell; code 3 does nothing.
// Result channel: out_valid is high for exactly one cycle with out_item
// (cursor location, cell data for a read, scroll flag). The receiver
// cannot stall; take the result in that cycle.
// Sequence: put without scroll, read and no-op execute and then strobe the
// result; the next item transfers only after the strobe, once the block
// is idle again. A put that scrolls copies 1920 cells at one per cycle
// and blanks 80 more; clear blanks all 2000 cells; both then strobe. The
// single write port of the cell store makes these sweeps one cell at a time.
// Configuration: cfg_ready is always high; cfg_data transfers with cfg_valid.
// Reset: synchronous, active low. Afterwards busy stays high while a
// clearing pass writes blank cells (space, attribute 0x0F) and then
// while the last write lands.
module text_console_writer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tcw_pkg::in_item_t  in_item,
  output logic               out_valid,
  output tcw_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);
  import tcw_pkg::*;

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  // Attribute writes never wait
  assign cfg_ready = 1'b1;

  // Sequence the operation: accept, execute, sweep the store, strobe
  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Hold the cells, cursor and attribute; drive the result fields
  tcw_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_item)
  );

endmodule

[sim/testbench.sv]
// Self-checking testbench for the text console writer: directed and random traffic
module testbench;
  import tcw_pkg::*;

  // Operation code 3 does nothing but report the cursor
  localparam logic [FUNC_W-1:0] OP_NONE = 2'd3;
  // Last byte that is written to the screen; bytes above it are ignored
  localparam logic [CHAR_W-1:0] CH_LAST_PRINT = 8'h7F;
  localparam int                INDEX_TOP = (1 << LOC_W) - 1;
  // Worst case: every transfer a scroll plus the longest
  // sender gap, over roughly 1300 items, then taken several times over
  localparam int unsigned       CYCLE_LIMIT = 12_000_000;

  typedef struct {
    out_item_t   res;
    int unsigned seq;
  } reply_due_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_item = '0;
  logic      cfg_valid = 1'b0;
  logic [7:0] cfg_data = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;
  logic      cfg_ready;

  // Console model: attribute register, cursor and the cell store
  logic [ATTR_W-1:0] text_attr;
  int                cur_col;
  int                cur_row;
  logic [CELL_W-1:0] screen_model [CELL_COUNT];

  reply_due_t  replies_due [$];
  reply_due_t  reply_head;
  int unsigned items_sent;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  text_console_writer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Blank every cell from the given index to the end of the store
  function automatic void blank_from(input int first);
    for (int i = first; i < CELL_COUNT; i++) begin
      screen_model[i] = {text_attr, CH_SPACE};
    end
  endfunction

  // Advance the console model by one command and return the result it owes
  function automatic out_item_t console_step(input in_item_t it);
    out_item_t         res;
    logic [CHAR_W-1:0] c;
    res = '0;
    c   = it.char_code;
    case (it.func)
      OP_PUT: begin
        if (c == CH_BACKSPACE) begin
          // backspace stops at the left edge
          if (cur_col != 0) cur_col--;
        end else if (c == CH_TAB) begin
          cur_col = (cur_col / TAB_WIDTH + 1) * TAB_WIDTH;
        end else if (c == CH_CR) begin
          cur_col = 0;
        end else if (c == CH_LF) begin
          cur_col = 0;
          cur_row++;
        end else if (c >= CH_SPACE && c <= CH_LAST_PRINT) begin
          screen_model[cur_row * COLUMNS + cur_col] = {text_attr, c};
          cur_col++;
        end
        // other control bytes and the upper half of the byte range drop out here
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        // below the last row: shift every row up and blank the bottom one
        if (cur_row >= ROWS) begin
          for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
            screen_model[i] = screen_model[i + COLUMNS];
          end
          blank_from((ROWS - 1) * COLUMNS);
          cur_row      = ROWS - 1;
          res.scrolled = 1'b1;
        end
      end
      OP_CLEAR: begin
        blank_from(0);
        cur_col = 0;
        cur_row = 0;
      end
      OP_READ: begin
        // reads past the end of the store return zero
        if (it.cell_index < CELL_COUNT) res.cell_data = screen_model[it.cell_index];
      end
      default: ;
    endcase
    res.cursor_location = LOC_W'(cur_row * COLUMNS + cur_col);
    return res;
  endfunction

  function automatic in_item_t make_item(input logic [FUNC_W-1:0] f,
                                         input logic [CHAR_W-1:0] ch,
                                         input logic [LOC_W-1:0]  idx);
    in_item_t it;
    it.func       = f;
    it.char_code  = ch;
    it.cell_index = idx;
    return it;
  endfunction

  // Sender gap: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 50) $display("MISMATCH: %s", msg);
  endtask

  // Hold start high until the command transfers, then record its expected result.
  // The task first waits for a clock edge, so start is never lowered and raised in one step.
  task automatic send_item(input in_item_t it, input int unsigned extra_gap);
    reply_due_t due;
    @(posedge clk);
    repeat (extra_gap) @(posedge clk);
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    // transfer taken at this edge; drop start and scramble the idle payload
    start   <= 1'b0;
    in_item <= in_item_t'($urandom);
    due.res = console_step(it);
    due.seq = items_sent;
    replies_due.push_back(due);
    items_sent++;
  endtask

  // Hold off until the block is idle and every result has come back
  task automatic wait_drained();
    @(posedge clk);
    while (busy !== 1'b0 || replies_due.size() != 0) @(posedge clk);
  endtask

  // Write the attribute register, only ever with the block idle
  task automatic set_attribute(input logic [ATTR_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_data  <= 8'($urandom);
    text_attr = value;
  endtask

  // Store after the clearing pass: blank cells, nothing beyond the end
  task automatic test_reset_contents();
    send_item(make_item(OP_READ, 8'h00, LOC_W'(0)), 0);
    send_item(make_item(OP_READ, 8'hFF, LOC_W'(CELL_COUNT - 1)), 0);
    send_item(make_item(OP_READ, 8'h00, LOC_W'(CELL_COUNT)), 0);
    send_item(make_item(OP_READ, 8'h00, LOC_W'(INDEX_TOP)), 0);
  endtask

  // Every cursor control, printable extremes, ignored bytes and each operation
  task automatic test_put_controls();
    set_attribute(8'h00);
    send_item(make_item(OP_PUT, CH_SPACE, '0), 0);
    send_item(make_item(OP_PUT, CH_LAST_PRINT, LOC_W'(INDEX_TOP)), 0);
    send_item(make_item(OP_PUT, 8'h41, '0), 0);
    send_item(make_item(OP_PUT, CH_BACKSPACE, '0), 0);
    send_item(make_item(OP_PUT, CH_TAB, '0), 0);
    send_item(make_item(OP_PUT, CH_CR, '0), 0);
    // backspace at the left edge stays put
    send_item(make_item(OP_PUT, CH_BACKSPACE, '0), 0);
    send_item(make_item(OP_PUT, CH_LF, '0), 0);
    send_item(make_item(OP_PUT, 8'h00, '0), 0);
    send_item(make_item(OP_PUT, 8'h1F, '0), 0);
    send_item(make_item(OP_PUT, 8'h80, '0), 0);
    send_item(make_item(OP_PUT, 8'hFF, '0), 0);
    send_item(make_item(OP_READ, 8'h00, LOC_W'(0)), 0);
    send_item(make_item(OP_READ, 8'h00, LOC_W'(1)), 0);
    send_item(make_item(OP_READ, 8'h00, LOC_W'(2)), 0);
    send_item(make_item(OP_NONE, 8'hFF, LOC_W'(INDEX_TOP)), 0);
    set_attribute(8'hFF);
    send_item(make_item(OP_PUT, 8'h5A, '0), 0);
    send_item(make_item(OP_READ, 8'h00, LOC_W'(COLUMNS)), 0);
    send_item(make_item(OP_CLEAR, 8'h00, '0), 0);
    send_item(make_item(OP_READ, 8'h00, LOC_W'(1)), 0);
  endtask

  // Walk to the bottom row, then scroll by line feed and by a wrapping tab
  task automatic test_scroll();
    int base;
    set_attribute(8'($urandom));
    for (int i = 0; i < ROWS - 1; i++) send_item(make_item(OP_PUT, CH_LF, '0), pick_gap());
    for (int i = 0; i < 3; i++) begin
      send_item(make_item(OP_PUT, 8'($urandom_range(CH_SPACE, CH_LAST_PRINT)), '0), 0);
    end
    base = (ROWS - 1) * COLUMNS;
    send_item(make_item(OP_READ, 8'h00, LOC_W'(base + 1)), 0);
    set_attribute(8'($urandom));
    send_item(make_item(OP_PUT, CH_LF, '0), 0);
    // old bottom row moved up one, new bottom row blank in the new attribute
    send_item(make_item(OP_READ, 8'h00, LOC_W'(base - COLUMNS + 1)), 0);
    send_item(make_item(OP_READ, 8'h00, LOC_W'(base + 1)), pick_gap());
    for (int i = 0; i < COLUMNS / TAB_WIDTH; i++) begin
      send_item(make_item(OP_PUT, CH_TAB, '0), pick_gap());
    end
    send_item(make_item(OP_READ, 8'h00, LOC_W'(base - COLUMNS + 2)), 0);
    send_item(make_item(OP_CLEAR, 8'h00, '0), 0);
  endtask

  // Mixed traffic, mostly printable puts, with line-feed runs to reach the
  // bottom row so that scrolls come often, and reads aimed just behind the cursor
  task automatic test_random_traffic(input int count, input bit no_idle);
    int                r;
    int                loc;
    int unsigned       gap;
    logic [FUNC_W-1:0] f;
    logic [CHAR_W-1:0] ch;
    logic [LOC_W-1:0]  idx;
    for (int n = 0; n < count; n++) begin
      // now and then run down towards the bottom row
      if (n % 40 == 0 && $urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(18, ROWS + 1)) send_item(make_item(OP_PUT, CH_LF, '0), 0);
      end
      // pause the sender until everything outstanding has come back
      if ($urandom_range(0, 19) == 0) wait_drained();
      r   = $urandom_range(0, 99);
      f   = OP_PUT;
      ch  = 8'($urandom);
      idx = LOC_W'($urandom);
      if (r < 50) ch = 8'($urandom_range(CH_SPACE, CH_LAST_PRINT));
      else if (r < 56) ch = CH_BACKSPACE;
      else if (r < 61) ch = CH_TAB;
      else if (r < 64) ch = CH_CR;
      else if (r < 67) ch = CH_LF;
      else if (r < 70) ch = 8'($urandom_range(0, CH_SPACE - 1));
      else if (r < 74) ch = 8'($urandom_range(CH_LAST_PRINT + 1, 8'hFF));
      else if (r < 90) begin
        f   = OP_READ;
        loc = cur_row * COLUMNS + cur_col;
        r   = $urandom_range(0, 9);
        if (r < 5 && loc >= 3) idx = LOC_W'(loc - $urandom_range(1, 3));
        else if (r < 9) idx = LOC_W'($urandom_range(0, CELL_COUNT - 1));
        else idx = LOC_W'($urandom_range(CELL_COUNT, INDEX_TOP));
      end else if (r < 92) f = OP_CLEAR;
      else if (r < 95) f = OP_NONE;
      gap = no_idle ? 0 : pick_gap();
      send_item(make_item(f, ch, idx), gap);
    end
  endtask

  // Compare each result strobe against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (replies_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result, location %0d data %h",
                                  out_item.cursor_location, out_item.cell_data));
      end else begin
        reply_head = replies_due.pop_front();
        if (out_item.cursor_location !== reply_head.res.cursor_location)
          report_mismatch($sformatf("item %0d cursor_location got %0d want %0d",
                                    reply_head.seq, out_item.cursor_location,
                                    reply_head.res.cursor_location));
        if (out_item.cell_data !== reply_head.res.cell_data)
          report_mismatch($sformatf("item %0d cell_data got %h want %h", reply_head.seq,
                                    out_item.cell_data, reply_head.res.cell_data));
        if (out_item.scrolled !== reply_head.res.scrolled)
          report_mismatch($sformatf("item %0d scrolled got %b want %b", reply_head.seq,
                                    out_item.scrolled, reply_head.res.scrolled));
      end
    end
  end

  // Guard against a hung block
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [ATTR_W-1:0] phase_attr [6];
    items_sent     = 0;
    text_attr      = ATTR_RESET;
    cur_col        = 0;
    cur_row        = 0;
    blank_from(0);
    phase_attr = '{8'h00, 8'hFF, 8'($urandom), ATTR_RESET, 8'($urandom), 8'hA5};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // the first reads wait out the clearing pass through busy
    test_reset_contents();
    test_put_controls();
    test_scroll();
    for (int p = 0; p < 6; p++) begin
      set_attribute(phase_attr[p]);
      test_random_traffic(180, p == 2);
    end

    wait_drained();
    // leave room for any stray strobe
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
